[rtl/core/dtlv_pkg.sv]
// Shared types and constants for the DER TLV byte encoder.
`default_nettype none

package dtlv_pkg;

  // Request kinds as carried on the request channel.
  typedef enum logic [1:0] {
    KIND_HDR      = 2'd0,
    KIND_RAW      = 2'd1,
    KIND_ARC      = 2'd2,
    KIND_ARC_PAIR = 2'd3
  } kind_e;

  // Serialiser operation after classification.
  typedef enum logic [1:0] {
    OP_HDR  = 2'd0,
    OP_RAW  = 2'd1,
    OP_B128 = 2'd2
  } op_e;

  localparam int unsigned ValW     = 32;
  localparam int unsigned OctW     = 8;
  localparam int unsigned NumW     = 3;   // octets per request, 1..6

  localparam logic [ValW-1:0] ShortLenMax = 32'd127;
  localparam logic [OctW-1:0] LongLenMark = 8'h80;
  localparam logic [OctW-1:0] ContBit     = 8'h80;
  localparam logic [6:0]      GroupMask   = 7'h7f;
  localparam logic [ValW-1:0] ArcMul      = 32'd40;

  // One classified request, front to back.
  typedef struct packed {
    op_e             op;
    logic [OctW-1:0] octet;   // tag or raw content byte
    logic [ValW-1:0] val;     // length or (combined) arc
    logic [NumW-1:0] nbytes;  // total octets to emit
  } desc_t;

endpackage

`default_nettype wire

[rtl/core/dtlv_if.sv]
// Valid/ready channel interfaces for requests and encoded octets.
`default_nettype none

interface dtlv_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tag;
  logic [31:0] value;
  logic [1:0]  first_arc;
  logic [7:0]  content_byte;

  modport source (output valid, kind, tag, value, first_arc, content_byte, input ready);
  modport sink   (input valid, kind, tag, value, first_arc, content_byte, output ready);
endinterface

interface dtlv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

[rtl/core/dtlv_front.sv]
// Front end: accepts requests, forms the arc value and counts output octets.
`default_nettype none

module dtlv_front
  import dtlv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  tag_i,
  input  wire logic [31:0] value_i,
  input  wire logic [1:0]  first_arc_i,
  input  wire logic [7:0]  content_byte_i,
  output logic             push_valid_o,
  input  wire logic        push_ready_i,
  output desc_t            push_desc_o
);

  logic  v_q, v_d;
  desc_t desc_q, desc_d;
  logic [ValW-1:0] arc_val;
  kind_e kind;

  assign kind       = kind_e'(kind_i);
  assign in_ready_o = !v_q || push_ready_i;

  // first_arc*40 + value, wraps at 32 bits
  assign arc_val = value_i + ({30'd0, first_arc_i} * ArcMul);

  always_comb begin
    desc_d       = desc_q;
    desc_d.octet = tag_i;
    desc_d.val   = value_i;
    case (kind)
      KIND_HDR: begin
        desc_d.op = OP_HDR;
        if (value_i <= ShortLenMax)        desc_d.nbytes = 3'd2;
        else if (value_i[31:24] != 8'd0)   desc_d.nbytes = 3'd6;
        else if (value_i[23:16] != 8'd0)   desc_d.nbytes = 3'd5;
        else if (value_i[15:8] != 8'd0)    desc_d.nbytes = 3'd4;
        else                               desc_d.nbytes = 3'd3;
      end
      KIND_RAW: begin
        desc_d.op     = OP_RAW;
        desc_d.octet  = content_byte_i;
        desc_d.nbytes = 3'd1;
      end
      default: begin
        desc_d.op  = OP_B128;
        desc_d.val = (kind == KIND_ARC) ? value_i : arc_val;
        if (desc_d.val[31:28] != 4'd0)      desc_d.nbytes = 3'd5;
        else if (desc_d.val[27:21] != 7'd0) desc_d.nbytes = 3'd4;
        else if (desc_d.val[20:14] != 7'd0) desc_d.nbytes = 3'd3;
        else if (desc_d.val[13:7] != 7'd0)  desc_d.nbytes = 3'd2;
        else                                desc_d.nbytes = 3'd1;
      end
    endcase
  end

  always_comb begin
    v_d = v_q;
    if (in_ready_o) v_d = in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) desc_q <= desc_d;
  end

  assign push_valid_o = v_q;
  assign push_desc_o  = desc_q;

endmodule

`default_nettype wire

[rtl/core/dtlv_fifo.sv]
// Small register queue of classified requests between front and back.
`default_nettype none

module dtlv_fifo
  import dtlv_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire desc_t push_desc_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output desc_t      pop_desc_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntFull);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_desc_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    if (push && !pop)      cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_desc_i;
  end

endmodule

`default_nettype wire

[rtl/core/dtlv_back.sv]
// Back end: serialises one classified request into octets, one per cycle while the output is not stalled.
`default_nettype none

module dtlv_back
  import dtlv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pop_valid_i,
  output logic             pop_ready_o,
  input  wire desc_t       pop_desc_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [OctW-1:0]  out_byte_o,
  output logic             out_last_o
);

  desc_t           cur_q;
  logic            cur_v_q, cur_v_d;
  logic [NumW-1:0] rem_q, rem_d;   // octets left after the current one
  logic [NumW-1:0] pos_q, pos_d;   // index of the current octet
  logic            ov_q, ov_d;
  logic [OctW-1:0] ob_q, ob_d;
  logic            ol_q, ol_d;
  logic            adv, done, load;
  logic [5:0]      sh8, sh7;
  logic [ValW-1:0] v8, v7;
  logic [OctW-1:0] oct;

  assign adv  = cur_v_q && (!ov_q || out_ready_i);
  assign done = adv && (rem_q == '0);
  assign load = pop_valid_i && (!cur_v_q || done);
  assign pop_ready_o = !cur_v_q || done;

  // big-endian length octet and base-128 group selected by octets remaining
  assign sh8 = {rem_q, 3'b000};
  assign sh7 = {rem_q, 3'b000} - {3'b000, rem_q};
  assign v8  = cur_q.val >> sh8;
  assign v7  = cur_q.val >> sh7;

  always_comb begin
    case (cur_q.op)
      OP_HDR: begin
        if (pos_q == '0)
          oct = cur_q.octet;
        else if (pos_q == 3'd1 && cur_q.nbytes > 3'd2)
          oct = LongLenMark | OctW'(cur_q.nbytes - 3'd2);
        else
          oct = v8[OctW-1:0];
      end
      OP_B128: begin
        oct = {1'b0, v7[6:0] & GroupMask};
        if (rem_q != '0) oct = oct | ContBit;
      end
      default: oct = cur_q.octet;
    endcase
  end

  always_comb begin
    cur_v_d = cur_v_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    ov_d    = ov_q;
    ob_d    = ob_q;
    ol_d    = ol_q;
    if (adv) begin
      rem_d = rem_q - 1'b1;
      pos_d = pos_q + 1'b1;
      ov_d  = 1'b1;
      ob_d  = oct;
      ol_d  = (rem_q == '0);
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (done) cur_v_d = 1'b0;
    if (load) begin
      cur_v_d = 1'b1;
      rem_d   = pop_desc_i.nbytes - 1'b1;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      ov_q    <= 1'b0;
      rem_q   <= '0;
      pos_q   <= '0;
    end else begin
      cur_v_q <= cur_v_d;
      ov_q    <= ov_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= pop_desc_i;
    ob_q <= ob_d;
    ol_q <= ol_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;

endmodule

`default_nettype wire

[rtl/core/der_tlv_byte_encoder.sv]
// Top level of the DER TLV byte encoder.
//
// Each request word on req_i becomes a run of one to six DER octets on byte_o,
// with last set on the final octet of the run: a header gives the tag and a
// short or long form length (two to six octets), a content request passes one
// octet through, and an arc request (optionally combined as first_arc*40+value,
// modulo 2^32) gives one to five base-128 groups. The output emits one octet
// per cycle while byte_o is not stalled, and a request holds the serialiser
// until all of its octets (one to six) are out; that serialiser sets the
// sustained rate. A front stage classifies requests and counts their octets,
// a queue of QueueDepth entries decouples it from the serialiser, and a
// registered output stage lets a new request be accepted while an octet waits.
// Requests pass the front register, the queue and the serialiser to the output
// register. No state is kept between requests and no configuration exists.
`default_nettype none

module der_tlv_byte_encoder
  import dtlv_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  dtlv_req_if.sink     req_i,
  dtlv_byte_if.source  byte_o
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  desc_t push_desc, pop_desc;

  dtlv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (req_i.ready),
    .kind_i         (req_i.kind),
    .tag_i          (req_i.tag),
    .value_i        (req_i.value),
    .first_arc_i    (req_i.first_arc),
    .content_byte_i (req_i.content_byte),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_desc_o    (push_desc)
  );

  // decoupling queue: front keeps accepting while long headers drain
  dtlv_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_desc_i  (push_desc),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_desc_o   (pop_desc)
  );

  // serialiser with registered octet output
  dtlv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_desc_i  (pop_desc),
    .out_valid_o (byte_o.valid),
    .out_ready_i (byte_o.ready),
    .out_byte_o  (byte_o.out_byte),
    .out_last_o  (byte_o.last)
  );

endmodule

`default_nettype wire

[rtl/core/dtlv_checker.sv]
// Port-level checks for the DER TLV byte encoder, bound to the top level.
`default_nettype none

module dtlv_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i
);

  logic [7:0] pend_q, pend_d;
  logic       in_acc, run_end;

  assign in_acc  = in_valid_i && in_ready_i;
  assign run_end = out_valid_i && out_ready_i && out_last_i;

  // requests accepted whose final octet has not yet gone out
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !run_end)      pend_d = pend_q + 8'd1;
    else if (run_end && !in_acc) pend_d = pend_q - 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("octet changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 8'd0)
    else $error("octet without an outstanding request");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 8'd0 |-> in_ready_i)
    else $error("empty block refuses a request");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_end |-> pend_q != 8'd0 || in_acc)
    else $error("run ended with no request outstanding");

endmodule

bind der_tlv_byte_encoder dtlv_checker u_dtlv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (byte_o.valid),
  .out_ready_i (byte_o.ready),
  .out_byte_i  (byte_o.out_byte),
  .out_last_i  (byte_o.last)
);

`default_nettype wire
